FILE: rtl/core/linear_probe_key_value_store_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe key/value store.
// Each macro takes a label, a clock, an active-low reset, a trigger and a
// consequence, and reports a failure by $error.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_KEY_VALUE_STORE_ASSERT_SVH
`define LINEAR_PROBE_KEY_VALUE_STORE_ASSERT_SVH

// The consequence must hold in the same cycle as the trigger.
`define LPKV_ASSERT_SAME(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequence must hold in the cycle after the trigger.
`define LPKV_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/lpkv_pkg.sv
// ----------------------------------------------------------------------------
// lpkv_pkg
// Types, constants and control structs shared by the key/value store.
// ----------------------------------------------------------------------------
package lpkv_pkg;

	// The slot count is a power of two, so the start slot is a mask of the key.
	localparam int TABLE_SIZE = 512;
	localparam int SLOT_W     = $clog2(TABLE_SIZE);
	localparam int LOAD_LIMIT = TABLE_SIZE * 3 / 4;
	localparam int CNT_W      = $clog2(LOAD_LIMIT + 2);
	localparam int KEY_W      = 32;
	localparam int VAL_W      = 32;
	localparam int STATUS_W   = 3;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_HIT      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MISS     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0]    read_value;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic [1:0] {
		RV_ZERO,
		RV_MISS,
		RV_RAM
	} rv_sel_t;

	typedef struct packed {
		logic                clr_wr;
		logic                accept;
		logic                rd;
		logic                step;
		logic                set_res;
		logic [STATUS_W-1:0] res_status;
		rv_sel_t             rv_sel;
		logic                wr_key;
		logic                wr_val;
		logic                cnt_inc;
		logic                rsp_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic key_zero;
		logic op_insert;
		logic key_match;
		logic slot_empty;
		logic below_limit;
		logic probe_last;
		logic rsp_free;
	} stat_t;

endpackage

FILE: rtl/core/lpkv_ram.sv
// ----------------------------------------------------------------------------
// lpkv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lpkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/lpkv_datapath.sv
// ----------------------------------------------------------------------------
// lpkv_datapath
// Request and probe registers, key and value memories, entry count,
// miss value register and the result and output registers.
// ----------------------------------------------------------------------------
module lpkv_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lpkv_pkg::req_t             req,
	input  logic                       cfg_we,
	input  logic [lpkv_pkg::VAL_W-1:0] cfg_wdata,
	input  logic                       rsp_stall,
	output logic                       rsp_valid,
	output lpkv_pkg::rsp_t             rsp,
	input  lpkv_pkg::cmd_t             cmd,
	output lpkv_pkg::stat_t            stat
);
	import lpkv_pkg::*;

	req_t              req_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] probe_q;
	logic [SLOT_W-1:0] clr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VAL_W-1:0]  miss_q;
	rsp_t              res_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              key_we;
	logic [SLOT_W-1:0] key_waddr;
	logic [KEY_W-1:0]  key_wdata;
	logic [KEY_W-1:0]  key_rdata;
	logic [VAL_W-1:0]  val_rdata;
	logic [VAL_W-1:0]  res_value;

	assign key_we    = cmd.clr_wr | cmd.wr_key;
	assign key_waddr = cmd.clr_wr ? clr_q : slot_q;
	assign key_wdata = cmd.clr_wr ? '0 : req_q.key;

	lpkv_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_SIZE)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_wdata),
		.re   (cmd.rd),
		.raddr(slot_q),
		.rdata(key_rdata)
	);

	lpkv_ram #(
		.WIDTH(VAL_W),
		.DEPTH(TABLE_SIZE)
	) u_val_ram (
		.clk  (clk),
		.we   (cmd.wr_val),
		.waddr(slot_q),
		.wdata(req_q.value),
		.re   (cmd.rd),
		.raddr(slot_q),
		.rdata(val_rdata)
	);

	always_comb begin
		case (cmd.rv_sel)
			RV_MISS: res_value = miss_q;
			RV_RAM:  res_value = val_rdata;
			default: res_value = '0;
		endcase
	end

	assign stat.clr_last    = (clr_q == SLOT_W'(TABLE_SIZE - 1));
	assign stat.key_zero    = (req_q.key == '0);
	assign stat.op_insert   = (req_q.operation == OP_INSERT);
	assign stat.key_match   = (key_rdata == req_q.key);
	assign stat.slot_empty  = (key_rdata == '0);
	assign stat.below_limit = (cnt_q <= CNT_W'(LOAD_LIMIT));
	assign stat.probe_last  = (probe_q == SLOT_W'(TABLE_SIZE - 1));
	assign stat.rsp_free    = ~rsp_valid_q | ~rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			miss_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cfg_we) begin
				miss_q <= cfg_wdata;
			end
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q   <= req;
			slot_q  <= req.key[SLOT_W-1:0];
			probe_q <= '0;
		end else if (cmd.step) begin
			slot_q  <= slot_q + 1'b1;
			probe_q <= probe_q + 1'b1;
		end
		if (cmd.set_res) begin
			res_q.read_value <= res_value;
			res_q.status     <= cmd.res_status;
		end
		if (cmd.rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/core/lpkv_ctrl.sv
// ----------------------------------------------------------------------------
// lpkv_ctrl
// Controller: clearing pass, request intake, probe sequencing and
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module lpkv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  lpkv_pkg::stat_t stat,
	output lpkv_pkg::cmd_t  cmd
);
	import lpkv_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOAD,
		S_CMP,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   stall_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid && !stall_q) begin
					cmd.accept = 1'b1;
					state_d    = S_LOAD;
				end
			end
			S_LOAD: begin
				if (stat.key_zero) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = stat.op_insert ? ST_FULL : ST_MISS;
					cmd.rv_sel     = stat.op_insert ? RV_ZERO : RV_MISS;
					state_d        = S_DONE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (stat.key_match) begin
					cmd.set_res = 1'b1;
					state_d     = S_DONE;
					if (stat.op_insert) begin
						cmd.wr_val     = 1'b1;
						cmd.res_status = ST_REPLACED;
						cmd.rv_sel     = RV_ZERO;
					end else begin
						cmd.res_status = ST_HIT;
						cmd.rv_sel     = RV_RAM;
					end
				end else if (stat.slot_empty || stat.probe_last) begin
					cmd.set_res = 1'b1;
					state_d     = S_DONE;
					if (!stat.op_insert) begin
						cmd.res_status = ST_MISS;
						cmd.rv_sel     = RV_MISS;
					end else if (stat.slot_empty && stat.below_limit) begin
						cmd.wr_key     = 1'b1;
						cmd.wr_val     = 1'b1;
						cmd.cnt_inc    = 1'b1;
						cmd.res_status = ST_INSERTED;
						cmd.rv_sel     = RV_ZERO;
					end else begin
						cmd.res_status = ST_FULL;
						cmd.rv_sel     = RV_ZERO;
					end
				end else begin
					cmd.step = 1'b1;
					state_d  = S_LOAD;
				end
			end
			S_DONE: begin
				if (stat.rsp_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			stall_q <= 1'b1;
		end else begin
			state_q <= state_d;
			stall_q <= (state_d != S_IDLE);
		end
	end

	assign req_stall = stall_q;

endmodule

FILE: rtl/core/linear_probe_key_value_store.sv
// Requests are taken one at a time: req_stall stays high from acceptance until the result
// is loaded into the output register, and a stalled output holds that load back.
// A zero key makes no probe.
// Each probe is one registered read of the key memory, then one compare of the read key.
// After reset a clearing pass writes zero to every slot of the key memory; requests
// are stalled during it, while miss value writes are taken at once.
// ----------------------------------------------------------------------------
// linear_probe_key_value_store
// Open-addressed key/value table with linear probing and a load limit.
// ----------------------------------------------------------------------------
module linear_probe_key_value_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  lpkv_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output lpkv_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic [lpkv_pkg::VAL_W-1:0] cfg_wdata
);
	import lpkv_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lpkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lpkv_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

FILE: rtl/core/lpkv_checker.sv
// ----------------------------------------------------------------------------
// lpkv_checker
// Port-level checks on the key/value store, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_probe_key_value_store_assert.svh"

module lpkv_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_stall,
	input lpkv_pkg::req_t             req,
	input logic                       rsp_valid,
	input logic                       rsp_stall,
	input lpkv_pkg::rsp_t             rsp,
	input logic                       cfg_we,
	input logic [lpkv_pkg::VAL_W-1:0] cfg_wdata
);
	import lpkv_pkg::*;

	logic insert_result;

	assign insert_result = (rsp.status == ST_INSERTED) || (rsp.status == ST_REPLACED) ||
		(rsp.status == ST_FULL);

	`LPKV_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid)
	`LPKV_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && rsp_stall, $stable(rsp))
	`LPKV_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && !req_stall, req_stall)
	`LPKV_ASSERT_SAME(a_insert_zero, clk, arst_n, rsp_valid && insert_result,
		rsp.read_value == '0)

endmodule

bind linear_probe_key_value_store lpkv_checker u_lpkv_checker (.*);
